// File: hdl/aes_pkg.sv
`default_nettype none

package aes_pkg;

    localparam int NUM_ROUND_KEYS = 15;
    localparam int RK_AW          = $clog2(NUM_ROUND_KEYS);
    localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(NUM_ROUND_KEYS - 1);
    localparam int PADDR_W        = 6;

    // register map, 8-byte stride
    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_IV_HIGH = 3'd4;
    localparam logic [2:0] REG_IV_LOW  = 3'd5;

    localparam logic [127:0] PAD_BLOCK = {16{8'h10}};

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  byte_count;
        logic        first_block;
        logic        last_block;
    } plain_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic        final_result;
    } cipher_t;

    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        logic [127:0]     data;
    } rk_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } seq_state_t;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [10:0] base;
        base = {x, 3'b000};
        return SBOX_TABLE[11'd2047 - base -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

`default_nettype wire

// File: hdl/aes_ram.sv
`default_nettype none

module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/aes_key_exp.sv
`default_nettype none

// AES-256 key schedule: one 128-bit round key per cycle into the key store
module aes_key_exp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [255:0]   key,
    output aes_pkg::rk_wr_t     rk_wr,
    output logic                busy
);

    logic                      busy_reg, busy_next;
    logic [aes_pkg::RK_AW-1:0] cnt_reg, cnt_next;
    logic [255:0]              win_reg, win_next;
    logic [7:0]                rcon_reg, rcon_next;
    logic [31:0]               t;
    logic [31:0]               n0, n1, n2, n3;

    always_comb
    begin
        // previous eight words sit in win_reg, oldest in the top bits
        if (!cnt_reg[0])
        begin
            t = aes_pkg::sub_word({win_reg[23:0], win_reg[31:24]}) ^ {rcon_reg, 24'h0};
        end
        else
        begin
            t = aes_pkg::sub_word(win_reg[31:0]);
        end
        n0 = win_reg[255:224] ^ t;
        n1 = win_reg[223:192] ^ n0;
        n2 = win_reg[191:160] ^ n1;
        n3 = win_reg[159:128] ^ n2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        win_next  = win_reg;
        rcon_next = rcon_reg;
        rk_wr.en   = busy_reg;
        rk_wr.addr = cnt_reg;
        rk_wr.data = {n0, n1, n2, n3};
        if (cnt_reg == '0)
        begin
            rk_wr.data = key[255:128];
        end
        else if (cnt_reg == aes_pkg::RK_AW'(1))
        begin
            rk_wr.data = win_reg[127:0];
        end

        if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '0)
            begin
                win_next  = key;
                rcon_next = 8'h01;
            end
            else if (cnt_reg != aes_pkg::RK_AW'(1))
            begin
                win_next = {win_reg[127:0], n0, n1, n2, n3};
                if (!cnt_reg[0])
                begin
                    rcon_next = aes_pkg::xtime(rcon_reg);
                end
            end
            if (cnt_reg == aes_pkg::LAST_ROUND)
            begin
                busy_next = 1'b0;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        rcon_reg <= rcon_next;
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: hdl/aes_round.sv
`default_nettype none

// one cipher round; the first pass is the plain key addition
module aes_round (
    input  wire logic [127:0] state_in,
    input  wire logic [127:0] round_key,
    input  wire logic         key_only,
    input  wire logic         final_round,
    output logic      [127:0] state_out
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] mixed;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = aes_pkg::sbox(state_in[127 - 8*i -: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[c*4 + r] = s[((c + r) % 4)*4 + r];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            m[c*4]     = aes_pkg::xtime(t[c*4]) ^ aes_pkg::xtime(t[c*4+1]) ^ t[c*4+1]
                         ^ t[c*4+2] ^ t[c*4+3];
            m[c*4 + 1] = t[c*4] ^ aes_pkg::xtime(t[c*4+1]) ^ aes_pkg::xtime(t[c*4+2])
                         ^ t[c*4+2] ^ t[c*4+3];
            m[c*4 + 2] = t[c*4] ^ t[c*4+1] ^ aes_pkg::xtime(t[c*4+2])
                         ^ aes_pkg::xtime(t[c*4+3]) ^ t[c*4+3];
            m[c*4 + 3] = aes_pkg::xtime(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2]
                         ^ aes_pkg::xtime(t[c*4+3]);
        end
        for (int i = 0; i < 16; i++)
        begin
            mixed[127 - 8*i -: 8] = final_round ? t[i] : m[i];
        end
        state_out = (key_only ? state_in : mixed) ^ round_key;
    end

endmodule

`default_nettype wire

// File: hdl/aes256_cbc_encrypt.sv
// AES-256 CBC encryptor with PKCS#7 padding.
// Key words and IV are written over the APB port (8-byte stride, 64-bit data).
// A key write re-expands the round-key store, one round key per
// cycle, during which plain is stalled. The same expansion runs after reset.
// plain carries one 16-byte word with byte count and first/last flags; it is
// taken when plain_valid is high and plain_stall low. cipher carries one
// ciphertext word and final_result under cipher_valid/cipher_stall.
// Each word runs through the shared round unit (key add plus 14 rounds, with
// the next key read ahead from the registered key store), then moves into the
// output register, which raises cipher_valid. No new word is taken until the
// result has left for the output register. A full last word adds a padding
// word chained from it. plain_stall stays high for the whole of that work.
// A stalled cipher word holds in the output register; the core waits with its
// finished result until the register frees.
// Reset clears keys, IV and chain value, then the zero key is expanded.
`default_nettype none

module aes256_cbc_encrypt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [aes_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [63:0]                  pwdata,
    output logic      [63:0]                  prdata,
    output logic                              pready,
    input  wire logic                         plain_valid,
    output logic                              plain_stall,
    input  wire aes_pkg::plain_t              plain,
    output logic                              cipher_valid,
    input  wire logic                         cipher_stall,
    output aes_pkg::cipher_t                  cipher
);

    logic [255:0] key_reg;
    logic [127:0] iv_reg;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] state_reg, state_next;
    logic [aes_pkg::RK_AW-1:0] rnd_reg, rnd_next;
    logic         extra_reg, extra_next;
    logic         final_reg, final_next;
    logic         out_valid_reg, out_valid_next;
    aes_pkg::cipher_t out_reg, out_next;
    aes_pkg::seq_state_t st_reg, st_next;

    logic         cfg_wr;
    logic         kx_busy;
    aes_pkg::rk_wr_t rk_wr;
    logic [aes_pkg::RK_AW-1:0] rk_rd_addr;
    logic [127:0] rk_data;
    logic [127:0] round_out;
    logic         accept;
    logic         out_free;
    logic [4:0]   n_bytes;
    logic [7:0]   pad_val;
    logic [127:0] plain_blk;
    logic [127:0] padded;
    logic [127:0] chain_src;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            iv_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                aes_pkg::REG_KEY0:    key_reg[255:192] <= pwdata;
                aes_pkg::REG_KEY1:    key_reg[191:128] <= pwdata;
                aes_pkg::REG_KEY2:    key_reg[127:64]  <= pwdata;
                aes_pkg::REG_KEY3:    key_reg[63:0]    <= pwdata;
                aes_pkg::REG_IV_HIGH: iv_reg[127:64]   <= pwdata;
                aes_pkg::REG_IV_LOW:  iv_reg[63:0]     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            aes_pkg::REG_KEY0:    prdata = key_reg[255:192];
            aes_pkg::REG_KEY1:    prdata = key_reg[191:128];
            aes_pkg::REG_KEY2:    prdata = key_reg[127:64];
            aes_pkg::REG_KEY3:    prdata = key_reg[63:0];
            aes_pkg::REG_IV_HIGH: prdata = iv_reg[127:64];
            aes_pkg::REG_IV_LOW:  prdata = iv_reg[63:0];
            default:              prdata = '0;
        endcase
    end

    aes_key_exp u_key_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_wr && (paddr[5:3] == aes_pkg::REG_KEY0 || paddr[5:3] == aes_pkg::REG_KEY1
                || paddr[5:3] == aes_pkg::REG_KEY2 || paddr[5:3] == aes_pkg::REG_KEY3)),
        .key   (key_reg),
        .rk_wr (rk_wr),
        .busy  (kx_busy)
    );

    aes_ram #(
        .WIDTH (128),
        .DEPTH (aes_pkg::NUM_ROUND_KEYS)
    ) u_rk_ram (
        .clk     (clk),
        .wr_en   (rk_wr.en),
        .wr_addr (rk_wr.addr),
        .wr_data (rk_wr.data),
        .rd_addr (rk_rd_addr),
        .rd_data (rk_data)
    );

    aes_round u_round (
        .state_in    (state_reg),
        .round_key   (rk_data),
        .key_only    (rnd_reg == '0),
        .final_round (rnd_reg == aes_pkg::LAST_ROUND),
        .state_out   (round_out)
    );

    // key for the next pass is fetched ahead through the registered key store read
    assign rk_rd_addr = (st_reg == aes_pkg::ST_RUN && rnd_reg != aes_pkg::LAST_ROUND)
                        ? rnd_reg + 1'b1 : '0;

    assign plain_stall = (st_reg != aes_pkg::ST_IDLE) || kx_busy || cfg_wr;
    assign accept      = plain_valid && !plain_stall;
    assign out_free    = !out_valid_reg || !cipher_stall;
    assign plain_blk   = {plain.block_high, plain.block_low};

    always_comb
    begin
        n_bytes = (plain.byte_count > 5'd16) ? 5'd16 : plain.byte_count;
        pad_val = 8'd16 - {3'b000, n_bytes};
        for (int i = 0; i < 16; i++)
        begin
            if (plain.last_block && (5'(i) >= n_bytes))
            begin
                padded[127 - 8*i -: 8] = pad_val;
            end
            else
            begin
                padded[127 - 8*i -: 8] = plain_blk[127 - 8*i -: 8];
            end
        end
        chain_src = plain.first_block ? iv_reg : chain_reg;
    end

    always_comb
    begin
        st_next        = st_reg;
        state_next     = state_reg;
        chain_next     = chain_reg;
        rnd_next       = rnd_reg;
        extra_next     = extra_reg;
        final_next     = final_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && cipher_stall;
        case (st_reg)
            aes_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = padded ^ chain_src;
                    rnd_next   = '0;
                    extra_next = plain.last_block && (n_bytes == 5'd16);
                    final_next = plain.last_block && (n_bytes != 5'd16);
                    st_next    = aes_pkg::ST_RUN;
                end
            end
            aes_pkg::ST_RUN:
            begin
                state_next = round_out;
                rnd_next   = rnd_reg + 1'b1;
                if (rnd_reg == aes_pkg::LAST_ROUND)
                begin
                    st_next = aes_pkg::ST_OUT;
                end
            end
            aes_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_next.cipher_high  = state_reg[127:64];
                    out_next.cipher_low   = state_reg[63:0];
                    out_next.final_result = final_reg;
                    out_valid_next        = 1'b1;
                    chain_next            = state_reg;
                    if (extra_reg)
                    begin
                        // full last word: append a whole padding word
                        state_next = aes_pkg::PAD_BLOCK ^ state_reg;
                        rnd_next   = '0;
                        extra_next = 1'b0;
                        final_next = 1'b1;
                        st_next    = aes_pkg::ST_RUN;
                    end
                    else
                    begin
                        st_next = aes_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = aes_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= aes_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
            rnd_reg       <= '0;
            extra_reg     <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
            rnd_reg       <= rnd_next;
            extra_reg     <= extra_next;
            final_reg     <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        out_reg   <= out_next;
    end

    assign cipher_valid = out_valid_reg;
    assign cipher       = out_reg;

endmodule

`default_nettype wire

// File: dv/aes256_cbc_encrypt_tb.sv
`default_nettype none

module aes256_cbc_encrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 40;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [aes_pkg::PADDR_W-1:0] paddr;
    logic [63:0] pwdata, prdata;
    logic pready;
    logic plain_valid, plain_stall;
    aes_pkg::plain_t plain;
    logic cipher_valid, cipher_stall;
    aes_pkg::cipher_t cipher;

    aes256_cbc_encrypt uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .plain_valid(plain_valid), .plain_stall(plain_stall), .plain(plain),
        .cipher_valid(cipher_valid), .cipher_stall(cipher_stall), .cipher(cipher)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [63:0] key_regs [4];
    logic [63:0] iv_regs [2];
    logic [127:0] sched [aes_pkg::NUM_ROUND_KEYS];
    logic [127:0] chain;

    aes_pkg::plain_t  pending_words [$];
    aes_pkg::cipher_t expected_words [$];
    int fail_count;

    function automatic void queue_plain(input aes_pkg::plain_t p);
        pending_words = {pending_words, p};
    endfunction

    function automatic void queue_expect(input aes_pkg::cipher_t c);
        expected_words = {expected_words, c};
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] subst(input logic [7:0] x);
        logic [7:0] y, r;
        y = x;
        for (int i = 0; i < 6; i++) y = gmul(gmul(y, y), x);
        y = gmul(y, y);
        r = y;
        for (int i = 1; i < 5; i++) r ^= (y << i) | (y >> (8 - i));
        return r ^ 8'h63;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] t);
        return {subst(t[31:24]), subst(t[23:16]), subst(t[15:8]), subst(t[7:0])};
    endfunction

    function automatic void build_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            w[i] = i[0] ? key_regs[i/2][31:0] : key_regs[i/2][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i-1];
            if (i % 8 == 0)
            begin
                t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end
            else if (i % 8 == 4)
                t = subst_word(t);
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r < aes_pkg::NUM_ROUND_KEYS; r++)
            sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    // byte i of the state is bits 127-8i
    function automatic logic [127:0] encrypt_block(input logic [127:0] din);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] q;
        q = din ^ sched[0];
        for (int i = 0; i < 16; i++) s[i] = q[127-8*i -: 8];
        for (int r = 1; r < aes_pkg::NUM_ROUND_KEYS; r++)
        begin
            for (int i = 0; i < 16; i++) s[i] = subst(s[i]);
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[c*4+i] = s[((c+i)%4)*4+i];
            for (int c = 0; c < 4; c++)
            begin
                if (r < aes_pkg::NUM_ROUND_KEYS - 1)
                begin
                    s[c*4]   = gmul(t[c*4],2) ^ gmul(t[c*4+1],3) ^ t[c*4+2] ^ t[c*4+3];
                    s[c*4+1] = t[c*4] ^ gmul(t[c*4+1],2) ^ gmul(t[c*4+2],3) ^ t[c*4+3];
                    s[c*4+2] = t[c*4] ^ t[c*4+1] ^ gmul(t[c*4+2],2) ^ gmul(t[c*4+3],3);
                    s[c*4+3] = gmul(t[c*4],3) ^ t[c*4+1] ^ t[c*4+2] ^ gmul(t[c*4+3],2);
                end
                else
                    for (int i = 0; i < 4; i++) s[c*4+i] = t[c*4+i];
            end
            for (int i = 0; i < 16; i++) s[i] ^= sched[r][127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) q[127-8*i -: 8] = s[i];
        return q;
    endfunction

    function automatic void emit_cipher(input logic [127:0] din, input logic fin);
        aes_pkg::cipher_t c;
        chain = encrypt_block(din ^ chain);
        c.cipher_high  = chain[127:64];
        c.cipher_low   = chain[63:0];
        c.final_result = fin;
        queue_expect(c);
    endfunction

    function automatic void predict_cipher(input aes_pkg::plain_t p);
        logic [127:0] blk;
        int n;
        n = (p.byte_count > 16) ? 16 : p.byte_count;
        blk = {p.block_high, p.block_low};
        if (p.first_block) chain = {iv_regs[0], iv_regs[1]};
        if (!p.last_block)
            emit_cipher(blk, 1'b0);
        else if (n < 16)
        begin
            for (int i = n; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - n);
            emit_cipher(blk, 1'b1);
        end
        else
        begin
            emit_cipher(blk, 1'b0);
            emit_cipher(aes_pkg::PAD_BLOCK, 1'b1);
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= aes_pkg::PADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < aes_pkg::REG_IV_HIGH)
        begin
            key_regs[idx] = val;
            build_schedule();
        end
        else
            iv_regs[idx - aes_pkg::REG_IV_HIGH] = val;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic aes_pkg::plain_t make_word(input logic fb, input logic lb,
                                                  input int cnt);
        aes_pkg::plain_t p;
        p.block_high  = rand64();
        p.block_low   = rand64();
        p.byte_count  = 5'(cnt);
        p.first_block = fb;
        p.last_block  = lb;
        return p;
    endfunction

    // random messages, mostly well-formed with some loose words
    task automatic queue_messages(input int words);
        int len, cnt;
        int queued;
        queued = 0;
        while (queued < words)
        begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
            begin
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 16;
                if (i == len - 1 && $urandom_range(0, 1)) cnt = $urandom_range(0, 31);
                queue_plain(make_word(i == 0 || $urandom_range(0, 19) == 0,
                                      i == len - 1, cnt));
                queued++;
            end
        end
    endtask

    // acceptance seen at the rising edge, acted on at the next falling edge
    logic in_taken;
    logic out_taken;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end
        else
        begin
            in_taken  <= plain_valid && !plain_stall;
            out_taken <= cipher_valid && !cipher_stall;
        end
    end

    // driver
    int send_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_valid <= 1'b0;
            plain       <= '0;
            send_gap    <= 0;
        end
        else if (in_taken)
        begin
            predict_cipher(pending_words.pop_front());
            if (pending_words.size() != 0 && $urandom_range(0, 2) == 0)
            begin
                plain <= pending_words[0];
                send_gap <= 0;
            end
            else
            begin
                plain_valid <= 1'b0;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            end
        end
        else if (!plain_valid && pending_words.size() != 0)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else
            begin
                plain_valid <= 1'b1;
                plain <= pending_words[0];
            end
        end
    end

    // monitor; stall decided at the falling edge
    int recv_gap;
    int gap_now;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_stall <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_taken)
                gap_now = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            else
                gap_now = recv_gap;
            if (gap_now > 0)
            begin
                cipher_stall <= 1'b1;
                recv_gap <= gap_now - 1;
            end
            else
            begin
                cipher_stall <= 1'b0;
                recv_gap <= 0;
            end
        end
    end

    aes_pkg::cipher_t want;
    always @(posedge clk)
    begin
        if (rst_n && cipher_valid && !cipher_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, cipher);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (cipher.cipher_high !== want.cipher_high)
                begin
                    $display("%0t: cipher_high expected %h actual %h",
                             $time, want.cipher_high, cipher.cipher_high);
                    fail_count++;
                end
                if (cipher.cipher_low !== want.cipher_low)
                begin
                    $display("%0t: cipher_low expected %h actual %h",
                             $time, want.cipher_low, cipher.cipher_low);
                    fail_count++;
                end
                if (cipher.final_result !== want.final_result)
                begin
                    $display("%0t: final_result expected %b actual %b",
                             $time, want.final_result, cipher.final_result);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    int idle_cycles;
    always @(posedge clk)
    begin
        if ((plain_valid && !plain_stall) || (cipher_valid && !cipher_stall) || psel)
            idle_cycles <= 0;
        else if (pending_words.size() != 0 || expected_words.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("aes256_cbc_encrypt verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0; idle_cycles = 0;
        for (int i = 0; i < 4; i++) key_regs[i] = '0;
        iv_regs[0] = '0; iv_regs[1] = '0;
        chain = '0;
        build_schedule();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero key, zero IV: chain from reset value, then directed cases
        queue_plain(make_word(1'b0, 1'b0, 16));
        queue_plain(aes_pkg::plain_t'{64'h0, 64'h0, 5'd0, 1'b1, 1'b1});
        queue_plain(aes_pkg::plain_t'{'1, '1, 5'd31, 1'b1, 1'b1});
        wait_drained();

        reg_write(aes_pkg::REG_KEY0, '1);
        reg_write(aes_pkg::REG_KEY1, '1);
        reg_write(aes_pkg::REG_KEY2, '1);
        reg_write(aes_pkg::REG_KEY3, '1);
        reg_write(aes_pkg::REG_IV_HIGH, '1);
        reg_write(aes_pkg::REG_IV_LOW, '1);
        for (int n = 0; n <= 17; n++)
            queue_plain(make_word(n == 0, n != 3, n));
        // message continued after it ended, no first flag
        queue_plain(make_word(1'b0, 1'b1, 16));
        queue_plain(make_word(1'b0, 1'b0, 5));
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            reg_write(aes_pkg::REG_KEY0, rand64());
            reg_write(aes_pkg::REG_KEY1, rand64());
            reg_write(aes_pkg::REG_KEY2, rand64());
            reg_write(aes_pkg::REG_KEY3, rand64());
            reg_write(aes_pkg::REG_IV_HIGH, rand64());
            reg_write(aes_pkg::REG_IV_LOW, rand64());
            queue_messages(180);
            wait_drained();
        end

        if (fail_count == 0)
            $display("aes256_cbc_encrypt verification clean");
        else
            $display("aes256_cbc_encrypt verification failed");
        $finish;
    end

endmodule

`default_nettype wire
